@@ rtl/tmaf_pkg.sv @@
// Shared constants and types for the trackpoint motion acceleration filter.
`default_nettype none
package tmaf_pkg;

	localparam int HistDepth = 4;
	localparam int HistW     = 26;
	localparam int SumW      = HistW + $clog2(HistDepth) + 1;
	localparam int MagW      = 25;
	localparam int MulAW     = 37;
	localparam int MulBW     = 25;
	localparam int MulPW     = MulAW + MulBW;
	localparam int RadW      = 50;
	localparam int RootW     = 25;

	localparam logic [2:0] RegScale    = 3'd0;
	localparam logic [2:0] RegIncline  = 3'd1;
	localparam logic [2:0] RegOffset   = 3'd2;
	localparam logic [2:0] RegMaxAccel = 3'd3;
	localparam logic [2:0] RegMaxDelta = 3'd4;
	localparam logic [2:0] RegAccelEn  = 3'd5;

	typedef struct packed {
		logic            neg_x;
		logic [MagW-1:0] mag_x;
		logic            neg_y;
		logic [MagW-1:0] mag_y;
	} hist_avg_t;

endpackage
`default_nettype wire

@@ rtl/tmaf_in_if.sv @@
// Input channel carrying one raw motion event.
`default_nettype none
interface tmaf_in_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] dx;
	logic signed [8:0] dy;
	modport source (output valid, output dx, output dy, input ready);
	modport sink (input valid, input dx, input dy, output ready);
endinterface
`default_nettype wire

@@ rtl/tmaf_out_if.sv @@
// Output channel carrying one filtered motion result.
`default_nettype none
interface tmaf_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	modport source (output valid, output out_x, output out_y, input ready);
	modport sink (input valid, input out_x, input out_y, output ready);
endinterface
`default_nettype wire

@@ rtl/tmaf_hist.sv @@
// Motion history shift registers and averaging.
`default_nettype none
module tmaf_hist (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	input  wire signed [tmaf_pkg::HistW-1:0] sx,
	input  wire signed [tmaf_pkg::HistW-1:0] sy,
	output tmaf_pkg::hist_avg_t              avg
);
	logic signed [tmaf_pkg::HistW-1:0] hx_q [tmaf_pkg::HistDepth];
	logic signed [tmaf_pkg::HistW-1:0] hy_q [tmaf_pkg::HistDepth];
	logic signed [tmaf_pkg::SumW-1:0]  sum_x, sum_y;
	logic [tmaf_pkg::SumW-1:0]         abs_x, abs_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tmaf_pkg::HistDepth; i++) begin
				hx_q[i] <= '0;
				hy_q[i] <= '0;
			end
		end else if (push) begin
			hx_q[0] <= sx;
			hy_q[0] <= sy;
			for (int i = 1; i < tmaf_pkg::HistDepth; i++) begin
				hx_q[i] <= hx_q[i-1];
				hy_q[i] <= hy_q[i-1];
			end
		end
	end

	always_comb begin
		sum_x = '0;
		sum_y = '0;
		for (int i = 0; i < tmaf_pkg::HistDepth; i++) begin
			sum_x = sum_x + tmaf_pkg::SumW'(hx_q[i]);
			sum_y = sum_y + tmaf_pkg::SumW'(hy_q[i]);
		end
		abs_x = sum_x[tmaf_pkg::SumW-1] ? tmaf_pkg::SumW'(-sum_x) : tmaf_pkg::SumW'(sum_x);
		abs_y = sum_y[tmaf_pkg::SumW-1] ? tmaf_pkg::SumW'(-sum_y) : tmaf_pkg::SumW'(sum_y);
		// truncation toward zero: divide the magnitude, keep the sign
		avg.neg_x = sum_x[tmaf_pkg::SumW-1];
		avg.neg_y = sum_y[tmaf_pkg::SumW-1];
		avg.mag_x = tmaf_pkg::MagW'(abs_x / tmaf_pkg::HistDepth);
		avg.mag_y = tmaf_pkg::MagW'(abs_y / tmaf_pkg::HistDepth);
	end
endmodule
`default_nettype wire

@@ rtl/tmaf_mul.sv @@
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module tmaf_mul (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire [tmaf_pkg::MulAW-1:0]        a,
	input  wire [tmaf_pkg::MulBW-1:0]        b,
	output logic                             done,
	output logic [tmaf_pkg::MulPW-1:0]       prod
);
	localparam int CntW = $clog2(tmaf_pkg::MulBW);
	localparam logic [CntW-1:0] LastCnt = CntW'(tmaf_pkg::MulBW - 1);

	logic [tmaf_pkg::MulAW-1:0] a_q;
	logic [tmaf_pkg::MulPW-1:0] p_q;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q, done_q;
	logic [tmaf_pkg::MulAW:0]   psum;

	assign psum = {1'b0, p_q[tmaf_pkg::MulPW-1 -: tmaf_pkg::MulAW]}
		+ (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{tmaf_pkg::MulAW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {psum, p_q[tmaf_pkg::MulBW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;
endmodule
`default_nettype wire

@@ rtl/tmaf_sqrt.sv @@
// Digit-serial integer square root, one result bit per cycle.
`default_nettype none
module tmaf_sqrt (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire [tmaf_pkg::RadW-1:0]          rad,
	output logic                              done,
	output logic [tmaf_pkg::RootW-1:0]        root
);
	localparam int CntW = $clog2(tmaf_pkg::RootW);
	localparam int RemW = tmaf_pkg::RootW + 3;
	localparam logic [CntW-1:0] LastCnt = CntW'(tmaf_pkg::RootW - 1);

	logic [tmaf_pkg::RadW-1:0]  rad_q;
	logic [tmaf_pkg::RootW-1:0] root_q;
	logic [RemW-1:0]            rem_q, rem_n, trial;
	logic [CntW-1:0]            cnt_q;
	logic                       busy_q, done_q;

	assign rem_n = {rem_q[RemW-3:0], rad_q[tmaf_pkg::RadW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[tmaf_pkg::RadW-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[tmaf_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[tmaf_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ rtl/trackpoint_motion_accel_filter.sv @@
// Trackpoint motion filter: history average, serial acceleration, clipping.
// Usage:
//  - in_ch carries one raw (dx, dy) event; a transfer needs valid and ready high.
//  - out_ch carries one (out_x, out_y) result per event, in order.
//  - APB port writes and reads the six registers at byte address 4*i;
//    pready is always high, write only while the block is idle.
// Sequence:
//  - Accelerating mode: after the input transfer the block averages, forms the
//    two serial squares, the serial square root, magnitude*incline and the final
//    two serial products, then loads the output register.
//  - Constant mode: after averaging, the clipped average loads the output register.
//  - One event is in flight at a time; in_ch.ready is high only when idle,
//    so a new event is taken only after the last result has moved to the output register.
//    The serial multipliers and root unit are shared across the steps.
// Stall:
//  - A finished result waits in the output register; a new event is
//    still taken, and its result waits until the old one is transferred.
// Reset:
//  - arst_n clears the history to zero, loads register defaults, empties output.
`default_nettype none
module trackpoint_motion_accel_filter (
	input  wire               clk,
	input  wire               arst_n,
	tmaf_in_if.sink           in_ch,
	tmaf_out_if.source        out_ch,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [4:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AVG  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_FAC  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;

	logic [16:0] scale_q;
	logic [15:0] incline_q, offset_q, max_accel_q;
	logic [14:0] delta_lim_q;
	logic        accel_q;

	logic [2:0]  state_q;
	logic        in_fire, cfg_wr, out_load;
	logic [2:0]  cfg_idx;

	logic signed [26:0] px, py;
	tmaf_pkg::hist_avg_t avg;

	logic [tmaf_pkg::MagW-1:0] mx_q, my_q;
	logic                      nx_q, ny_q;

	logic                        m0_start, m1_start, m0_done, m1_done;
	logic [tmaf_pkg::MulAW-1:0]  m0_a, m1_a;
	logic [tmaf_pkg::MulBW-1:0]  m0_b, m1_b;
	logic [tmaf_pkg::MulPW-1:0]  p0, p1;
	logic                        sq_start, sq_done;
	logic [tmaf_pkg::RootW-1:0]  root;
	logic [tmaf_pkg::RadW-1:0]   rad;

	logic [42:0]                 fac_sum, fac_cap;
	logic [tmaf_pkg::MulAW-1:0]  factor_c;

	logic [15:0] res_x_q, res_y_q;
	logic        out_valid_q;
	logic [15:0] out_x_q, out_y_q;

	function automatic logic [15:0] clip_sign(input logic [25:0] m, input logic neg,
		input logic [14:0] lim);
		logic [15:0] c;
		c = (m > {11'd0, lim}) ? {1'b0, lim} : m[15:0];
		return neg ? 16'(-c) : c;
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= 17'd65536;
			incline_q   <= 16'd4260;
			offset_q    <= 16'd0;
			max_accel_q <= 16'd1178;
			delta_lim_q <= 15'd30720;
			accel_q     <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tmaf_pkg::RegScale:    scale_q <= (pwdata[16:0] > 17'd65536) ?
					17'd65536 : pwdata[16:0];
				tmaf_pkg::RegIncline:  incline_q   <= pwdata[15:0];
				tmaf_pkg::RegOffset:   offset_q    <= pwdata[15:0];
				tmaf_pkg::RegMaxAccel: max_accel_q <= pwdata[15:0];
				tmaf_pkg::RegMaxDelta: delta_lim_q <= pwdata[14:0];
				tmaf_pkg::RegAccelEn:  accel_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			tmaf_pkg::RegScale:    prdata = {15'd0, scale_q};
			tmaf_pkg::RegIncline:  prdata = {16'd0, incline_q};
			tmaf_pkg::RegOffset:   prdata = {16'd0, offset_q};
			tmaf_pkg::RegMaxAccel: prdata = {16'd0, max_accel_q};
			tmaf_pkg::RegMaxDelta: prdata = {17'd0, delta_lim_q};
			tmaf_pkg::RegAccelEn:  prdata = {31'd0, accel_q};
			default:               prdata = 32'd0;
		endcase
	end

	// input scaling and history
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign px = 27'($signed({{18{in_ch.dx[8]}}, in_ch.dx}) * $signed({10'd0, scale_q}));
	assign py = 27'($signed({{18{in_ch.dy[8]}}, in_ch.dy}) * $signed({10'd0, scale_q}));

	tmaf_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_fire),
		.sx     (px[tmaf_pkg::HistW-1:0]),
		.sy     (py[tmaf_pkg::HistW-1:0]),
		.avg    (avg)
	);

	// serial arithmetic units
	assign rad     = p0[tmaf_pkg::RadW-1:0] + p1[tmaf_pkg::RadW-1:0];
	assign fac_sum = {2'd0, p0[40:0]} + {11'd0, offset_q, 16'd0};
	assign fac_cap = {7'd0, max_accel_q, 20'd0};
	assign factor_c = (fac_sum > fac_cap) ? fac_cap[tmaf_pkg::MulAW-1:0]
		: fac_sum[tmaf_pkg::MulAW-1:0];

	assign m0_start = (state_q == S_AVG && accel_q) || (state_q == S_ROOT && sq_done)
		|| (state_q == S_FAC && m0_done);
	assign m1_start = (state_q == S_AVG && accel_q) || (state_q == S_FAC && m0_done);
	assign sq_start = (state_q == S_SQ && m0_done);

	always_comb begin
		case (state_q)
			S_AVG: begin
				m0_a = {12'd0, avg.mag_x};
				m0_b = avg.mag_x;
			end
			S_ROOT: begin
				m0_a = {21'd0, incline_q};
				m0_b = root;
			end
			default: begin
				m0_a = factor_c;
				m0_b = mx_q;
			end
		endcase
		if (state_q == S_AVG) begin
			m1_a = {12'd0, avg.mag_y};
			m1_b = avg.mag_y;
		end else begin
			m1_a = factor_c;
			m1_b = my_q;
		end
	end

	tmaf_mul u_mul0 (
		.clk (clk), .arst_n (arst_n), .start (m0_start),
		.a (m0_a), .b (m0_b), .done (m0_done), .prod (p0)
	);

	tmaf_mul u_mul1 (
		.clk (clk), .arst_n (arst_n), .start (m1_start),
		.a (m1_a), .b (m1_b), .done (m1_done), .prod (p1)
	);

	tmaf_sqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .start (sq_start),
		.rad (rad), .done (sq_done), .root (root)
	);

	// sequencer
	assign out_load = (state_q == S_WAIT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_AVG;
				S_AVG:  state_q <= accel_q ? S_SQ : S_WAIT;
				S_SQ:   if (m0_done) state_q <= S_ROOT;
				S_ROOT: if (sq_done) state_q <= S_FAC;
				S_FAC:  if (m0_done) state_q <= S_FIN;
				S_FIN:  if (m0_done && m1_done) state_q <= S_WAIT;
				S_WAIT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_AVG) begin
			mx_q    <= avg.mag_x;
			my_q    <= avg.mag_y;
			nx_q    <= avg.neg_x;
			ny_q    <= avg.neg_y;
			// constant mode result, dropped by the accelerated path later
			res_x_q <= clip_sign({9'd0, avg.mag_x[24:8]}, avg.neg_x, delta_lim_q);
			res_y_q <= clip_sign({9'd0, avg.mag_y[24:8]}, avg.neg_y, delta_lim_q);
		end
		if (state_q == S_FIN && m0_done) begin
			res_x_q <= clip_sign(p0[61:36], nx_q, delta_lim_q);
			res_y_q <= clip_sign(p1[61:36], ny_q, delta_lim_q);
		end
		if (out_load) begin
			out_x_q <= res_x_q;
			out_y_q <= res_y_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_x = out_x_q;
	assign out_ch.out_y = out_y_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_AVG)
		else $error("input transfer did not start averaging");
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		m0_done |-> (state_q == S_SQ || state_q == S_FAC || state_q == S_FIN))
		else $error("multiplier finished outside a multiply step");
	a_root_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_ROOT)
		else $error("square root finished outside its step");
	a_out_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ($signed(out_ch.out_x) <= $signed({2'b0, delta_lim_q})
		&& $signed(out_ch.out_x) >= -$signed({2'b0, delta_lim_q})
		&& $signed(out_ch.out_y) <= $signed({2'b0, delta_lim_q})
		&& $signed(out_ch.out_y) >= -$signed({2'b0, delta_lim_q})))
		else $error("output beyond delta limit");
`endif
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for the trackpoint motion acceleration filter: predicted results checked in order.
module tb;

	typedef struct packed {
		logic signed [15:0] ox;
		logic signed [15:0] oy;
	} motion_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tmaf_in_if in_ch();
	tmaf_out_if out_ch();

	trackpoint_motion_accel_filter i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state and configuration
	logic [16:0] cfg_scale;
	logic [15:0] cfg_incline, cfg_offset, cfg_max_accel;
	logic [14:0] cfg_delta_lim;
	logic        cfg_accel;
	longint      hx [tmaf_pkg::HistDepth];
	longint      hy [tmaf_pkg::HistDepth];
	motion_t     pending_motion [$];

	int  errors = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;      // no random idling
	bit  rx_hold = 1'b0;   // long receiver hold-off

	initial begin
		in_ch.valid = 1'b0;
		in_ch.dx = '0;
		in_ch.dy = '0;
		out_ch.ready = 1'b0;
	end

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] clip_component(longint avg, longint unsigned fac, bit acc);
		longint unsigned m = (avg < 0) ? -avg : avg;
		longint s;
		if (acc) m = (m * fac) >> 36;
		else m >>= 8;
		if (m > cfg_delta_lim) m = cfg_delta_lim;
		s = (avg < 0) ? -longint'(m) : longint'(m);
		return s[15:0];
	endfunction

	function automatic motion_t filter_motion(logic signed [8:0] dx, logic signed [8:0] dy);
		longint ax = 0, ay = 0;
		longint unsigned mx, my, fac = 0, cap;
		motion_t r;
		for (int i = tmaf_pkg::HistDepth - 1; i > 0; i--) begin
			hx[i] = hx[i-1];
			hy[i] = hy[i-1];
		end
		hx[0] = longint'(dx) * longint'(cfg_scale);
		hy[0] = longint'(dy) * longint'(cfg_scale);
		for (int i = 0; i < tmaf_pkg::HistDepth; i++) begin
			ax += hx[i];
			ay += hy[i];
		end
		ax = ax / tmaf_pkg::HistDepth;
		ay = ay / tmaf_pkg::HistDepth;
		if (cfg_accel) begin
			mx = (ax < 0) ? -ax : ax;
			my = (ay < 0) ? -ay : ay;
			cap = longint'(cfg_max_accel) << 20;
			fac = isqrt(mx * mx + my * my) * cfg_incline + (longint'(cfg_offset) << 16);
			if (fac > cap) fac = cap;
		end
		r.ox = clip_component(ax, fac, cfg_accel);
		r.oy = clip_component(ay, fac, cfg_accel);
		return r;
	endfunction

	// leaves the port in the access phase so writes can follow back to back
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			tmaf_pkg::RegScale:    cfg_scale = (val[16:0] > 17'd65536) ? 17'd65536 : val[16:0];
			tmaf_pkg::RegIncline:  cfg_incline = val[15:0];
			tmaf_pkg::RegOffset:   cfg_offset = val[15:0];
			tmaf_pkg::RegMaxAccel: cfg_max_accel = val[15:0];
			tmaf_pkg::RegMaxDelta: cfg_delta_lim = val[14:0];
			tmaf_pkg::RegAccelEn:  cfg_accel = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_motion.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(logic [16:0] sc, logic [15:0] inc, logic [15:0] off,
			logic [15:0] mxa, logic [14:0] mxd, logic acc);
		drain();
		reg_write(tmaf_pkg::RegScale, 32'(sc));
		reg_write(tmaf_pkg::RegIncline, 32'(inc));
		reg_write(tmaf_pkg::RegOffset, 32'(off));
		reg_write(tmaf_pkg::RegMaxAccel, 32'(mxa));
		reg_write(tmaf_pkg::RegMaxDelta, 32'(mxd));
		reg_write(tmaf_pkg::RegAccelEn, 32'(acc));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// valid stays up after the transfer; the next call reuses it for new data or drain() drops it
	task automatic send_motion(logic signed [8:0] dx, logic signed [8:0] dy);
		while (!calm && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.dx <= dx;
		in_ch.dy <= dy;
		@(posedge clk iff (in_ch.valid && in_ch.ready));
		pending_motion.push_back(filter_motion(dx, dy));
	endtask

	task automatic send_random(int n, bit small_only);
		logic signed [8:0] a, b;
		for (int i = 0; i < n; i++) begin
			if (small_only) begin
				a = 9'($signed($urandom_range(40)) - 20);
				b = 9'($signed($urandom_range(40)) - 20);
			end else begin
				a = 9'($urandom);
				b = 9'($urandom);
			end
			send_motion(a, b);
		end
	endtask

	task automatic test_directed();
		logic signed [8:0] ext [5] = '{-9'sd256, 9'sd255, 9'sd0, -9'sd1, 9'sd1};
		foreach (ext[i]) send_motion(ext[i], ext[4-i]);
		repeat (4) send_motion(9'sd255, 9'sd255);
		repeat (4) send_motion(-9'sd256, -9'sd256);
		// scale above one saturates, zero limit, constant mode
		set_config(17'h1ffff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff, 1'b1);
		repeat (4) send_motion(-9'sd256, 9'sd255);
		set_config(17'd65536, 16'd4260, 16'd0, 16'd1178, 15'd0, 1'b1);
		repeat (3) send_motion(9'sd100, -9'sd77);
		set_config(17'd0, 16'd0, 16'd0, 16'd0, 15'd30720, 1'b0);
		repeat (2) send_motion(9'sd200, 9'sd3);
		set_config(17'd65536, 16'd0, 16'd0, 16'd0, 15'd100, 1'b0);
		repeat (3) send_motion(-9'sd256, 9'sd255);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 8; p++) begin
			set_config(17'($urandom_range(70000)), 16'($urandom), 16'($urandom),
				16'($urandom), 15'($urandom), 1'($urandom_range(1)));
			send_random(150, p[0]);
		end
	endtask

	task automatic test_back_pressure();
		set_config(17'd65536, 16'd4260, 16'd0, 16'd1178, 15'd30720, 1'b0);
		fork
			begin
				rx_hold = 1'b1;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			send_random(50, 1'b0);
		join
		drain();
		calm = 1'b1;
		set_config(17'd40000, 16'd9000, 16'd100, 16'd3000, 15'd20000, 1'b1);
		send_random(150, 1'b0);
		calm = 1'b0;
		set_config(17'd65536, 16'd4260, 16'd0, 16'd1178, 15'd30720, 1'b1);
		send_random(230, 1'b0);
	endtask

	// checker and receiver
	always @(posedge clk) begin
		motion_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_motion.size() == 0) begin
					$display("%0t unexpected transfer: expected none actual %h %h", $time,
						out_ch.out_x, out_ch.out_y);
					errors++;
				end else begin
					want = pending_motion.pop_front();
					if (want.ox !== out_ch.out_x) begin
						$display("%0t out_x: expected %0d actual %0d", $time, want.ox,
							out_ch.out_x);
						errors++;
					end
					if (want.oy !== out_ch.out_y) begin
						$display("%0t out_y: expected %0d actual %0d", $time, want.oy,
							out_ch.out_y);
						errors++;
					end
				end
			end
			out_ch.ready <= !rx_hold && (calm || $urandom_range(99) >= 7);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		cfg_scale = 17'd65536;
		cfg_incline = 16'd4260;
		cfg_offset = 16'd0;
		cfg_max_accel = 16'd1178;
		cfg_delta_lim = 15'd30720;
		cfg_accel = 1'b1;
		foreach (hx[i]) begin
			hx[i] = 0;
			hy[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_back_pressure();
		drain();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/tmaf_pkg.sv
rtl/tmaf_in_if.sv
rtl/tmaf_out_if.sv
rtl/tmaf_hist.sv
rtl/tmaf_mul.sv
rtl/tmaf_sqrt.sv
rtl/trackpoint_motion_accel_filter.sv
bench/tb.sv
